/* sv/lokt_pkg.sv */
// Package for the level-order key table: sizes, codes and the
// command/status structs shared by the controller and the datapath.
// Depends on nothing.
package lokt_pkg;

  // Storage sizes.
  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(DEPTH + 1);

  // Fixed field widths of the request and response channels.
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DISPATCH,
    CS_SCAN,
    CS_WAIT_CMP,
    CS_EVAL,
    CS_READ_LAST,
    CS_MOVE,
    CS_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;      // latch the request, clear the scan state
    logic    ins_write;  // write the key at slot count, count grows
    logic    scan_rd;    // read the slot under the scan pointer
    logic    rd_last;    // read the final slot
    logic    move_wr;    // copy the final key into the hit slot, count shrinks
    logic    load_rsp;   // load the response register
    status_e rsp_status;
    logic    pos_slot;   // position is the recorded slot, else zero
  } lokt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              last_issue;
    logic              hit;
    logic              rsp_free;
  } lokt_sts_t;

endpackage

/* sv/lokt_if.sv */
// Valid/ready channel interfaces for requests and responses of the
// level-order key table. Depends on lokt_pkg.
interface lokt_req_if import lokt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface lokt_rsp_if import lokt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

/* sv/lokt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lokt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/lokt_dp.sv */
// Datapath of the level-order key table: request latch, key store, fill
// count, scan pointer with compare stage and response register.
// Depends on lokt_pkg and lokt_ram.
module lokt_dp import lokt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lokt_cmd_t           cmd_i,
  output lokt_sts_t           sts_o,
  input  logic [MODE_W-1:0]   req_mode_i,
  input  logic [KEY_W-1:0]    req_key_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic [STATUS_W-1:0] rsp_status_o,
  output logic [POS_W-1:0]    rsp_position_o,
  output logic [COUNT_W-1:0]  rsp_entry_count_o
);

  logic [MODE_W-1:0]    mode_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        scan_q;
  logic [AW-1:0]        cmp_addr_q;
  logic                 cmp_valid_q;
  logic                 hit_q;
  logic [AW-1:0]        slot_q;
  logic                 rsp_valid_q;
  logic [STATUS_W-1:0]  rsp_status_q;
  logic [POS_W-1:0]     rsp_pos_q;
  logic [COUNT_W-1:0]   rsp_cnt_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;
  logic [CW-1:0]        last_idx;
  logic                 match;

  assign last_idx = count_q - CW'(1);
  assign match    = cmp_valid_q && (ram_rdata == key_q);

  // Key store port steering: inserts write at the fill count, a delete moves
  // the final key into the hit slot.
  always_comb begin
    ram_we    = cmd_i.ins_write || cmd_i.move_wr;
    ram_waddr = cmd_i.move_wr ? slot_q : count_q[AW-1:0];
    ram_wdata = cmd_i.move_wr ? ram_rdata : key_q;
    ram_raddr = cmd_i.rd_last ? last_idx[AW-1:0] : scan_q[AW-1:0];
  end

  lokt_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Fill count update.
  always_comb begin
    count_d = count_q;
    if (cmd_i.ins_write) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.move_wr) begin
      count_d = last_idx;
    end
  end

  // Request latch (payload, no reset).
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= req_mode_i;
      key_q  <= KEY_WIDTH'(req_key_i);
    end
  end

  // Control registers: count, scan pointer, compare stage, hit record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_q      <= '0;
      cmp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      count_q     <= count_d;
      cmp_valid_q <= cmd_i.scan_rd;
      if (cmd_i.start) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_q <= scan_q + CW'(1);
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // Slot record: an insert keeps its write slot, a delete the last match, a search the first.
  always_ff @(posedge clk_i) begin
    cmp_addr_q <= scan_q[AW-1:0];
    if (cmd_i.ins_write) begin
      slot_q <= count_q[AW-1:0];
    end else if (match && (mode_q == MODE_DELETE || !hit_q)) begin
      slot_q <= cmp_addr_q;
    end
  end

  // Response register: a finished result waits here until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_rsp) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rsp) begin
      rsp_status_q <= cmd_i.rsp_status;
      rsp_pos_q    <= cmd_i.pos_slot ? POS_W'(slot_q) : '0;
      rsp_cnt_q    <= COUNT_W'(count_q);
    end
  end

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_status_o      = rsp_status_q;
  assign rsp_position_o    = rsp_pos_q;
  assign rsp_entry_count_o = rsp_cnt_q;

  // Status toward the controller.
  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.full       = (count_q == CW'(DEPTH));
    sts_o.empty      = (count_q == '0);
    sts_o.last_issue = ((scan_q + CW'(1)) == count_q);
    sts_o.hit        = hit_q;
    sts_o.rsp_free   = !rsp_valid_q || rsp_ready_i;
  end

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  // A delete move only happens after a recorded match.
  a_move_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move_wr |-> hit_q)
    else $error("move without a match");

  // Scan reads never pass the fill count.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> (scan_q < count_q))
    else $error("scan read beyond fill count");

endmodule

/* sv/lokt_ctrl.sv */
// Controller state machine of the level-order key table: sequences
// insert, scan, move and response load. Depends on lokt_pkg.
module lokt_ctrl import lokt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  lokt_sts_t sts_i,
  output lokt_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  status_e     res_q, res_d;
  logic        pos_slot_q, pos_slot_d;

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CS_IDLE;
      res_q      <= STATUS_MISS;
      pos_slot_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      res_q      <= res_d;
      pos_slot_q <= pos_slot_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    res_d          = res_q;
    pos_slot_d     = pos_slot_q;
    req_ready_o    = 1'b0;
    cmd_o          = '0;
    cmd_o.rsp_status = res_q;
    cmd_o.pos_slot   = pos_slot_q;
    case (state_q)
      CS_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = CS_DISPATCH;
        end
      end
      CS_DISPATCH: begin
        state_d    = CS_FINISH;
        res_d      = STATUS_MISS;
        pos_slot_d = 1'b0;
        case (sts_i.mode)
          MODE_INSERT: begin
            if (sts_i.full) begin
              res_d = STATUS_FULL;
            end else begin
              cmd_o.ins_write = 1'b1;
              res_d           = STATUS_OK;
              pos_slot_d      = 1'b1;
            end
          end
          MODE_DELETE, MODE_SEARCH: begin
            if (!sts_i.empty) begin
              state_d = CS_SCAN;
            end
          end
          default: begin
            res_d = STATUS_MISS;
          end
        endcase
      end
      CS_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.last_issue) begin
          state_d = CS_WAIT_CMP;
        end
      end
      CS_WAIT_CMP: begin
        state_d = CS_EVAL;
      end
      CS_EVAL: begin
        if (sts_i.hit) begin
          res_d      = STATUS_OK;
          pos_slot_d = 1'b1;
          state_d    = (sts_i.mode == MODE_DELETE) ? CS_READ_LAST : CS_FINISH;
        end else begin
          res_d      = STATUS_MISS;
          pos_slot_d = 1'b0;
          state_d    = CS_FINISH;
        end
      end
      CS_READ_LAST: begin
        cmd_o.rd_last = 1'b1;
        state_d       = CS_MOVE;
      end
      CS_MOVE: begin
        cmd_o.move_wr = 1'b1;
        state_d       = CS_FINISH;
      end
      CS_FINISH: begin
        if (sts_i.rsp_free) begin
          cmd_o.load_rsp = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  // An accepted request is always dispatched next.
  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == CS_DISPATCH))
    else $error("request not dispatched");

  // The scan ends in the cycle after its last read.
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_SCAN && sts_i.last_issue) |=> (state_q == CS_WAIT_CMP))
    else $error("scan did not end after last read");

  // A full table is only reported for an insert.
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_rsp && res_q == STATUS_FULL) |-> (sts_i.mode == MODE_INSERT))
    else $error("full status outside insert");

endmodule

/* sv/level_order_key_table.sv */
// Top level of the level-order key table: controller plus datapath.
// Depends on lokt_pkg, lokt_if, lokt_ram, lokt_dp and lokt_ctrl.
//
//   channel  dir  fields                           handshake
//   req_i    in   mode[1:0], key[31:0]             valid/ready
//   rsp_o    out  status, position, entry_count    valid/ready
//
// One request at a time. Insert, full insert, unused mode and any request on
// an empty table go from dispatch to finish, where the response register
// loads; search and delete on a nonempty table first scan count slots and
// pass the compare wait and evaluate states, a matching delete also the
// read-last and move states. The next request is taken in the cycle after the
// load. The one-port-read key store is read one slot per cycle during the scan,
// which dominates a request. Reset empties the table at once; no clearing pass.
// A stalled response waits in its own register while the next request is
// already taken; the one after that waits in finish until the register frees.
module level_order_key_table import lokt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  lokt_req_if.sink   req_i,
  lokt_rsp_if.source rsp_o
);

  lokt_cmd_t cmd;
  lokt_sts_t sts;

  lokt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lokt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_mode_i        (req_i.mode),
    .req_key_i         (req_i.key),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_position_o    (rsp_o.position),
    .rsp_entry_count_o (rsp_o.entry_count)
  );

endmodule
